// ----- hdl/ptbt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptbt_pkg: shared types and constants of the periodic task budget tracker
// Slot record, operation and status codes, register indexes, control state.
// ----------------------------------------------------------------------------
package ptbt_pkg;

    // Default table size
    localparam int MAX_SLOTS_DEF = 16;

    // Field widths
    localparam int CNT_W   = 32;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 4;
    localparam int STAT_W  = 2;
    localparam int CFG_DW  = 5;
    localparam int CFG_IW  = 1;
    // Common width for slot position compares (covers up to 128 slots)
    localparam int CMP_W   = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd1;
    localparam logic [OP_W-1:0] OP_SET  = 2'd2;
    localparam logic [OP_W-1:0] OP_READ = 2'd3;

    // Slot status codes
    localparam logic [STAT_W-1:0] ST_RUNNABLE = 2'd0;
    localparam logic [STAT_W-1:0] ST_RUNNING  = 2'd1;
    localparam logic [STAT_W-1:0] ST_WAITING  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_SCHED_ON = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_ACTIVE   = 1'd1;

    // One table slot
    typedef struct packed {
        logic              valid;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  elapsed;
        logic [CNT_W-1:0]  run_total;
        logic [CNT_W-1:0]  period;
        logic [CNT_W-1:0]  budget;
    } t_slot;

    // Operation in flight, handed to the slot update unit
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              visit;
        logic              hit;
        logic              enable;
        logic [CNT_W-1:0]  period;
        logic [CNT_W-1:0]  budget;
        logic [STAT_W-1:0] new_status;
    } t_upd_ctl;

    // Control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_fsm;

endpackage

// ----- hdl/ptbt_cell.sv -----
// ----------------------------------------------------------------------------
// ptbt_cell: one slot register of the rotating slot ring
// Holds one slot record and takes its neighbor's record when the ring shifts.
// ----------------------------------------------------------------------------
module ptbt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  ptbt_pkg::t_slot i_slot,
    output ptbt_pkg::t_slot o_slot
);
    import ptbt_pkg::*;

    t_slot r_slot;

    // Status and counters clear on reset; period and budget are written
    // by a load before use, so they follow the ring without a reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid     <= 1'b0;
            r_slot.status    <= ST_RUNNABLE;
            r_slot.used      <= '0;
            r_slot.elapsed   <= '0;
            r_slot.run_total <= '0;
        end else if (i_shift) begin
            r_slot.valid     <= i_slot.valid;
            r_slot.status    <= i_slot.status;
            r_slot.used      <= i_slot.used;
            r_slot.elapsed   <= i_slot.elapsed;
            r_slot.run_total <= i_slot.run_total;
        end
        if (i_shift) begin
            r_slot.period <= i_slot.period;
            r_slot.budget <= i_slot.budget;
        end
    end

    assign o_slot = r_slot;

endmodule

// ----- hdl/ptbt_upd.sv -----
// ----------------------------------------------------------------------------
// ptbt_upd: slot update unit at the wrap point of the ring
// Applies a tick visit, a load or a status write to the slot passing by.
// ----------------------------------------------------------------------------
module ptbt_upd (
    input  ptbt_pkg::t_slot    i_slot,
    input  ptbt_pkg::t_upd_ctl i_ctl,
    output ptbt_pkg::t_slot    o_slot
);
    import ptbt_pkg::*;

    logic [CNT_W-1:0] w_el_inc;
    logic [CNT_W-1:0] w_used_inc;
    logic [CNT_W-1:0] w_rt_inc;
    logic             w_running;
    logic             w_waiting;

    assign w_running  = (i_slot.status == ST_RUNNING);
    assign w_waiting  = (i_slot.status == ST_WAITING);
    assign w_el_inc   = i_slot.elapsed + 1'b1;
    assign w_used_inc = w_running ? i_slot.used + 1'b1 : i_slot.used;
    assign w_rt_inc   = w_running ? i_slot.run_total + 1'b1 : i_slot.run_total;

    always_comb begin
        o_slot = i_slot;
        case (i_ctl.op)
            OP_TICK: begin
                // Per-tick visit of an enabled slot
                if (i_ctl.visit && i_slot.valid) begin
                    o_slot.elapsed   = w_el_inc;
                    o_slot.used      = w_used_inc;
                    o_slot.run_total = w_rt_inc;
                    if (w_waiting && (w_el_inc >= i_slot.period)) begin
                        // period over: runnable again, fresh period
                        o_slot.status  = ST_RUNNABLE;
                        o_slot.used    = '0;
                        o_slot.elapsed = '0;
                    end
                    if (w_running && (w_used_inc == i_slot.budget)) begin
                        o_slot.status = ST_WAITING;
                    end
                end
            end
            OP_LOAD: begin
                if (i_ctl.hit) begin
                    o_slot.valid     = i_ctl.enable;
                    o_slot.period    = i_ctl.period;
                    o_slot.budget    = i_ctl.budget;
                    o_slot.status    = ST_RUNNABLE;
                    o_slot.used      = '0;
                    o_slot.elapsed   = '0;
                    o_slot.run_total = '0;
                end
            end
            OP_SET: begin
                // status code three is ignored
                if (i_ctl.hit && (i_ctl.new_status <= ST_WAITING)) begin
                    o_slot.status = i_ctl.new_status;
                end
            end
            default: begin
                o_slot = i_slot;
            end
        endcase
    end

endmodule

// ----- hdl/periodic_task_budget_tracker.sv -----
// ----------------------------------------------------------------------------
// periodic_task_budget_tracker: periodic thread slot table with budgets
// Slots live in a ring of cells that rotates once per item through an
// update unit, so every slot is visited, loaded, set or read in turn.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  in       | in        | i_in_valid/o_in_stall | operation, slot fields
//  out      | out       | o_out_valid/i_out_stall | tick total, switch, read
//  cfg      | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  Each item passes from its transfer through one full ring rotation
//  through the single update unit, then its result is handed to the
//  output register. The input stalls until that hand-off is done, so
//  a new item is not taken before the last one is through the ring.
//  The next item is taken while a finished result waits in the output register.
//  Synchronous active-low reset clears the table status and counters at once.
//  Configuration writes are always taken (o_cfg_ready is held high).
// ----------------------------------------------------------------------------
module periodic_task_budget_tracker #(
    parameter int MAX_SLOTS = ptbt_pkg::MAX_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input item channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ptbt_pkg::OP_W-1:0]      i_operation,
    input  logic [ptbt_pkg::IDX_W-1:0]     i_slot_index,
    input  logic                           i_slot_enable,
    input  logic [ptbt_pkg::CNT_W-1:0]     i_period_ticks,
    input  logic [ptbt_pkg::CNT_W-1:0]     i_budget_ticks,
    input  logic [ptbt_pkg::STAT_W-1:0]    i_new_status,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ptbt_pkg::CNT_W-1:0]     o_tick_total,
    output logic                           o_switch_request,
    output logic [ptbt_pkg::STAT_W-1:0]    o_slot_status,
    output logic                           o_slot_enabled,
    output logic [ptbt_pkg::CNT_W-1:0]     o_slot_used,
    output logic [ptbt_pkg::CNT_W-1:0]     o_slot_elapsed,
    output logic [ptbt_pkg::CNT_W-1:0]     o_slot_running_time,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ptbt_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [ptbt_pkg::CFG_DW-1:0]    i_cfg_data
);
    import ptbt_pkg::*;

    localparam int POS_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    // Configuration registers
    logic              r_sched_on;
    logic [CFG_DW-1:0] r_active;

    // Control
    t_fsm              r_state;
    t_fsm              n_state;
    logic [POS_W-1:0]  r_pos;
    logic              w_in_xfer;
    logic              w_out_free;
    logic              w_shift;
    logic              w_load_out;

    // Latched item
    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_idx;
    logic              r_en;
    logic [CNT_W-1:0]  r_period;
    logic [CNT_W-1:0]  r_budget;
    logic [STAT_W-1:0] r_new_status;

    // Global tick count and pending result
    logic [CNT_W-1:0]  r_tick;
    logic              r_res_sw;
    logic [STAT_W-1:0] r_res_status;
    logic              r_res_en;
    logic [CNT_W-1:0]  r_res_used;
    logic [CNT_W-1:0]  r_res_elapsed;
    logic [CNT_W-1:0]  r_res_rt;

    // Output register
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_out_tick;
    logic              r_out_sw;
    logic [STAT_W-1:0] r_out_status;
    logic              r_out_en;
    logic [CNT_W-1:0]  r_out_used;
    logic [CNT_W-1:0]  r_out_elapsed;
    logic [CNT_W-1:0]  r_out_rt;

    // Ring
    t_slot             w_cell_q [MAX_SLOTS];
    t_slot             w_tail;
    t_slot             w_upd;
    t_upd_ctl          w_ctl;
    logic              w_hit;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sched_on <= 1'b0;
            r_active   <= CFG_DW'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SCHED_ON: r_sched_on <= i_cfg_data[0];
                CFG_ACTIVE:   r_active   <= i_cfg_data;
                default:      r_active   <= r_active;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_RUN;
            end
            S_RUN: begin
                if (r_pos == '0) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_shift    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_RUN:  w_shift    = 1'b1;
            S_HOLD: w_load_out = w_out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Ring position: slot index now leaving the last cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_in_xfer) begin
            r_pos <= POS_W'(MAX_SLOTS - 1);
        end else if (w_shift) begin
            r_pos <= r_pos - 1'b1;
        end
    end

    // Item latch
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op         <= i_operation;
            r_idx        <= i_slot_index;
            r_en         <= i_slot_enable;
            r_period     <= i_period_ticks;
            r_budget     <= i_budget_ticks;
            r_new_status <= i_new_status;
        end
    end

    // Global tick count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (w_in_xfer && (i_operation == OP_TICK)) begin
            r_tick <= r_tick + 1'b1;
        end
    end

    // Update unit control for the slot at the wrap point
    assign w_hit = (CMP_W'(r_pos) == CMP_W'(r_idx));
    assign w_tail = w_cell_q[MAX_SLOTS-1];

    always_comb begin
        w_ctl.op         = r_op;
        w_ctl.visit      = r_sched_on && (CMP_W'(r_pos) < CMP_W'(r_active));
        w_ctl.hit        = w_hit;
        w_ctl.enable     = r_en;
        w_ctl.period     = r_period;
        w_ctl.budget     = r_budget;
        w_ctl.new_status = r_new_status;
    end

    ptbt_upd u_upd (
        .i_slot (w_tail),
        .i_ctl  (w_ctl),
        .o_slot (w_upd)
    );

    // Cell row: cell 0 takes the updated slot, others take their neighbor
    for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
        if (k == 0) begin : g_head
            ptbt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_slot  (w_upd),
                .o_slot  (w_cell_q[k])
            );
        end else begin : g_body
            ptbt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_slot  (w_cell_q[k-1]),
                .o_slot  (w_cell_q[k])
            );
        end
    end

    // Pending result: read fields zero unless a read finds its slot
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_res_sw      <= (i_operation == OP_TICK) && r_sched_on;
            r_res_status  <= ST_RUNNABLE;
            r_res_en      <= 1'b0;
            r_res_used    <= '0;
            r_res_elapsed <= '0;
            r_res_rt      <= '0;
        end else if (w_shift && (r_op == OP_READ) && w_hit) begin
            r_res_status  <= w_tail.status;
            r_res_en      <= w_tail.valid;
            r_res_used    <= w_tail.used;
            r_res_elapsed <= w_tail.elapsed;
            r_res_rt      <= w_tail.run_total;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_tick    <= r_tick;
            r_out_sw      <= r_res_sw;
            r_out_status  <= r_res_status;
            r_out_en      <= r_res_en;
            r_out_used    <= r_res_used;
            r_out_elapsed <= r_res_elapsed;
            r_out_rt      <= r_res_rt;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_tick_total        = r_out_tick;
    assign o_switch_request    = r_out_sw;
    assign o_slot_status       = r_out_status;
    assign o_slot_enabled      = r_out_en;
    assign o_slot_used         = r_out_used;
    assign o_slot_elapsed      = r_out_elapsed;
    assign o_slot_running_time = r_out_rt;

    // Checks
    a_run_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> o_in_stall)
        else $error("input taken during ring rotation");

    a_xfer_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_RUN) && (r_pos == POS_W'(MAX_SLOTS - 1)))
        else $error("transfer did not start a full rotation");

    a_rot_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && (r_pos == '0) |=> (r_state == S_HOLD))
        else $error("rotation did not end after last slot");

    a_tick_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_switch_request |->
            (o_slot_used == '0) && (o_slot_elapsed == '0) && !o_slot_enabled)
        else $error("tick result carries read data");

endmodule

// ----- tb/tb_periodic_task_budget_tracker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_task_budget_tracker: self-checking bench of the slot tracker
// A directed table followed by random phases under changing scheduler
// settings. Results are compared with typed values or with a predictor of the slot table.
// ----------------------------------------------------------------------------
module tb_periodic_task_budget_tracker;
    import ptbt_pkg::*;

    localparam int SLOTS        = MAX_SLOTS_DEF;
    localparam int LATENCY      = SLOTS + 2;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 800;
    localparam int PHASES       = 8;
    localparam int LONG_HOLD    = 400;

    // Status code with no meaning; a set status carrying it is dropped
    localparam logic [STAT_W-1:0] ST_RESERVED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic              enable;
        logic [CNT_W-1:0]  period;
        logic [CNT_W-1:0]  budget;
        logic [STAT_W-1:0] status;
    } t_slot_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]  ticks;
        logic              switch_req;
        logic [STAT_W-1:0] status;
        logic              enabled;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  elapsed;
        logic [CNT_W-1:0]  run_time;
    } t_slot_report;

    // Directed rows: checked rows carry a typed result, predicted rows do not
    typedef enum logic [1:0] {
        ROW_CHECKED,
        ROW_PREDICTED,
        ROW_CONFIG
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic              enable;
        logic [CNT_W-1:0]  period;
        logic [CNT_W-1:0]  budget;
        logic [STAT_W-1:0] status;
        logic              sched_on;
        logic [CFG_DW-1:0] active;
        logic [CNT_W-1:0]  ticks;
        logic              switch_req;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [30] = '{
        // fresh table reads back as zeros
        '{ROW_CHECKED, OP_READ, 4'd0, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0},
        '{ROW_CHECKED, OP_READ, 4'd15, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0},
        // scheduler off: tick only counts
        '{ROW_CHECKED, OP_TICK, 4'd0, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd1, 1'b0},
        '{ROW_CHECKED, OP_LOAD, 4'd0, 1'b1, 32'd3, 32'd2, ST_RUNNABLE, 1'b0, 5'd0, 32'd1, 1'b0},
        '{ROW_CHECKED, OP_LOAD, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_RUNNABLE,
          1'b0, 5'd0, 32'd1, 1'b0},
        // zero budget
        '{ROW_CHECKED, OP_LOAD, 4'd1, 1'b1, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd1, 1'b0},
        // loaded but not enabled
        '{ROW_CHECKED, OP_LOAD, 4'd2, 1'b0, 32'd5, 32'd5, ST_RUNNABLE, 1'b0, 5'd0, 32'd1, 1'b0},
        '{ROW_CHECKED, OP_SET, 4'd0, 1'b0, 32'd0, 32'd0, ST_RUNNING, 1'b0, 5'd0, 32'd1, 1'b0},
        '{ROW_CHECKED, OP_SET, 4'd1, 1'b0, 32'd0, 32'd0, ST_RUNNING, 1'b0, 5'd0, 32'd1, 1'b0},
        // reserved status code is ignored
        '{ROW_CHECKED, OP_SET, 4'd3, 1'b0, 32'd0, 32'd0, ST_RESERVED, 1'b0, 5'd0, 32'd1, 1'b0},
        '{ROW_CHECKED, OP_READ, 4'd3, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd1, 1'b0},
        '{ROW_CHECKED, OP_SET, 4'd15, 1'b0, 32'd0, 32'd0, ST_WAITING, 1'b0, 5'd0, 32'd1, 1'b0},
        // scheduler on, full table: budget runs out, period refills
        '{ROW_CONFIG, OP_TICK, 4'd0, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b1, 5'd16, 32'd0, 1'b0},
        '{ROW_PREDICTED, OP_TICK, 4'd0, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0},
        '{ROW_PREDICTED, OP_TICK, 4'd0, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0},
        '{ROW_PREDICTED, OP_READ, 4'd0, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0},
        '{ROW_PREDICTED, OP_TICK, 4'd0, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0},
        '{ROW_PREDICTED, OP_READ, 4'd0, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0},
        '{ROW_PREDICTED, OP_READ, 4'd1, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0},
        // waiting slot with a zero period
        '{ROW_PREDICTED, OP_LOAD, 4'd4, 1'b1, 32'd0, 32'd1, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0},
        '{ROW_PREDICTED, OP_SET, 4'd4, 1'b0, 32'd0, 32'd0, ST_WAITING, 1'b0, 5'd0, 32'd0, 1'b0},
        // no slot visited
        '{ROW_CONFIG, OP_TICK, 4'd0, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b1, 5'd0, 32'd0, 1'b0},
        '{ROW_PREDICTED, OP_TICK, 4'd0, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0},
        '{ROW_PREDICTED, OP_READ, 4'd1, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0},
        // slot count above the table size
        '{ROW_CONFIG, OP_TICK, 4'd0, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b1, 5'd31, 32'd0, 1'b0},
        '{ROW_PREDICTED, OP_TICK, 4'd0, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0},
        '{ROW_PREDICTED, OP_READ, 4'd4, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0},
        '{ROW_PREDICTED, OP_READ, 4'd15, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0},
        '{ROW_CONFIG, OP_TICK, 4'd0, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd1, 32'd0, 1'b0},
        '{ROW_PREDICTED, OP_READ, 4'd2, 1'b0, 32'd0, 32'd0, ST_RUNNABLE, 1'b0, 5'd0, 32'd0, 1'b0}
    };

    // Clock and block ports
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_stall;
    logic [OP_W-1:0]   i_operation    = OP_TICK;
    logic [IDX_W-1:0]  i_slot_index   = '0;
    logic              i_slot_enable  = 1'b0;
    logic [CNT_W-1:0]  i_period_ticks = '0;
    logic [CNT_W-1:0]  i_budget_ticks = '0;
    logic [STAT_W-1:0] i_new_status   = ST_RUNNABLE;
    logic              o_out_valid;
    logic              i_out_stall    = 1'b0;
    logic [CNT_W-1:0]  o_tick_total;
    logic              o_switch_request;
    logic [STAT_W-1:0] o_slot_status;
    logic              o_slot_enabled;
    logic [CNT_W-1:0]  o_slot_used;
    logic [CNT_W-1:0]  o_slot_elapsed;
    logic [CNT_W-1:0]  o_slot_running_time;
    logic              i_cfg_valid    = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index    = CFG_SCHED_ON;
    logic [CFG_DW-1:0] i_cfg_data     = '0;

    // Predicted slot table and settings
    logic [CNT_W-1:0]  ticks_seen = '0;
    logic              sched_enabled = 1'b0;
    logic [CFG_DW-1:0] visit_limit = 5'd16;
    logic              slot_live   [SLOTS] = '{default: 1'b0};
    logic [STAT_W-1:0] slot_mode   [SLOTS] = '{default: ST_RUNNABLE};
    logic [CNT_W-1:0]  slot_spent  [SLOTS] = '{default: '0};
    logic [CNT_W-1:0]  slot_age    [SLOTS] = '{default: '0};
    logic [CNT_W-1:0]  slot_cpu    [SLOTS] = '{default: '0};
    logic [CNT_W-1:0]  slot_period [SLOTS] = '{default: '0};
    logic [CNT_W-1:0]  slot_budget [SLOTS] = '{default: '0};

    t_slot_report pending_reports [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           burst_left     = 0;
    bit           hold_req       = 1'b0;

    periodic_task_budget_tracker #(
        .MAX_SLOTS (SLOTS)
    ) i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_operation         (i_operation),
        .i_slot_index        (i_slot_index),
        .i_slot_enable       (i_slot_enable),
        .i_period_ticks      (i_period_ticks),
        .i_budget_ticks      (i_budget_ticks),
        .i_new_status        (i_new_status),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_tick_total        (o_tick_total),
        .o_switch_request    (o_switch_request),
        .o_slot_status       (o_slot_status),
        .o_slot_enabled      (o_slot_enabled),
        .o_slot_used         (o_slot_used),
        .o_slot_elapsed      (o_slot_elapsed),
        .o_slot_running_time (o_slot_running_time),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // One tick's effect on a single slot
    function automatic void age_slot(int s);
        if (!slot_live[s])
            return;
        slot_age[s] = slot_age[s] + 1;
        if (slot_mode[s] == ST_RUNNING) begin
            slot_spent[s] = slot_spent[s] + 1;
            slot_cpu[s]   = slot_cpu[s] + 1;
        end
        // period over: back to runnable with a fresh period
        if (slot_mode[s] == ST_WAITING && slot_age[s] >= slot_period[s]) begin
            slot_mode[s]  = ST_RUNNABLE;
            slot_spent[s] = '0;
            slot_age[s]   = '0;
        end
        // budget used up: wait for the next period
        if (slot_mode[s] == ST_RUNNING && slot_spent[s] == slot_budget[s])
            slot_mode[s] = ST_WAITING;
    endfunction

    // Applies one command to the predicted table and returns its report
    function automatic t_slot_report advance_tracker(t_slot_cmd c);
        t_slot_report r;
        int           lim;
        int           s;
        r = '0;
        case (c.op)
            OP_TICK: begin
                ticks_seen = ticks_seen + 1;
                if (sched_enabled) begin
                    lim = (visit_limit > SLOTS) ? SLOTS : int'(visit_limit);
                    for (s = 0; s < lim; s++)
                        age_slot(s);
                    r.switch_req = 1'b1;
                end
            end
            OP_LOAD: begin
                slot_live[c.idx]   = c.enable;
                slot_period[c.idx] = c.period;
                slot_budget[c.idx] = c.budget;
                slot_mode[c.idx]   = ST_RUNNABLE;
                slot_spent[c.idx]  = '0;
                slot_age[c.idx]    = '0;
                slot_cpu[c.idx]    = '0;
            end
            OP_SET: begin
                if (c.status != ST_RESERVED)
                    slot_mode[c.idx] = c.status;
            end
            default: begin
                r.status   = slot_mode[c.idx];
                r.enabled  = slot_live[c.idx];
                r.used     = slot_spent[c.idx];
                r.elapsed  = slot_age[c.idx];
                r.run_time = slot_cpu[c.idx];
            end
        endcase
        r.ticks = ticks_seen;
        return r;
    endfunction

    // Random command, mostly small periods and budgets so slots cycle
    function automatic t_slot_cmd make_cmd();
        t_slot_cmd c;
        int        pick;
        c.idx    = 4'($urandom_range(0, 15));
        c.enable = ($urandom_range(0, 9) != 0);
        c.period = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 12);
        c.budget = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6);
        pick = $urandom_range(0, 9);
        if (pick < 5)
            c.status = ST_RUNNING;
        else if (pick < 7)
            c.status = ST_WAITING;
        else if (pick < 9)
            c.status = ST_RUNNABLE;
        else
            c.status = ST_RESERVED;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            c.op = OP_TICK;
        else if (pick < 62)
            c.op = OP_READ;
        else if (pick < 78)
            c.op = OP_SET;
        else
            c.op = OP_LOAD;
        return c;
    endfunction

    function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Offers one command in bursts with random gaps; records its report
    task automatic send_cmd(t_slot_cmd c, bit typed_known, t_slot_report typed);
        int gap;
        t_slot_report predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_operation    <= c.op;
        i_slot_index   <= c.idx;
        i_slot_enable  <= c.enable;
        i_period_ticks <= c.period;
        i_budget_ticks <= c.budget;
        i_new_status   <= c.status;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = advance_tracker(c);
        pending_reports.push_back(typed_known ? typed : predicted);
    endtask

    // Stops offering and waits for every outstanding report
    task automatic finish_outstanding();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    // Writes both registers back to back
    task automatic program_tracker(logic on, logic [CFG_DW-1:0] active);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SCHED_ON;
        i_cfg_data  <= {4'($urandom_range(0, 15)), on};
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sched_enabled = on;
        i_cfg_index <= CFG_ACTIVE;
        i_cfg_data  <= active;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        visit_limit = active;
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: stall pattern, long hold on request, compare
    always @(posedge i_clk) begin : result_check
        t_slot_report want;
        int           rx_cycle;
        int           hold_left;
        if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result transfer, tick_total %0h", o_tick_total);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("tick_total", want.ticks, o_tick_total);
                check_field("switch_request", CNT_W'(want.switch_req),
                            CNT_W'(o_switch_request));
                check_field("slot_status", CNT_W'(want.status), CNT_W'(o_slot_status));
                check_field("slot_enabled", CNT_W'(want.enabled), CNT_W'(o_slot_enabled));
                check_field("slot_used", want.used, o_slot_used);
                check_field("slot_elapsed", want.elapsed, o_slot_elapsed);
                check_field("slot_running_time", want.run_time, o_slot_running_time);
            end
        end
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case ((rx_cycle >> 7) % 4)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= 1'($urandom_range(0, 1));
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_stim_row    row;
        t_slot_cmd    cmd;
        t_slot_report typed;
        int           r;
        int           phase;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (r = 0; r < $size(DIRECTED_ROWS); r++) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_CONFIG) begin
                finish_outstanding();
                program_tracker(row.sched_on, row.active);
            end else begin
                cmd.op     = row.op;
                cmd.idx    = row.idx;
                cmd.enable = row.enable;
                cmd.period = row.period;
                cmd.budget = row.budget;
                cmd.status = row.status;
                typed            = '0;
                typed.ticks      = row.ticks;
                typed.switch_req = row.switch_req;
                send_cmd(cmd, row.kind == ROW_CHECKED, typed);
            end
        end

        // random phases, settings change only once drained
        for (phase = 0; phase < PHASES; phase++) begin
            finish_outstanding();
            case (phase)
                0:       program_tracker(1'b1, 5'd16);
                1:       program_tracker(1'b1, 5'd1);
                2:       program_tracker(1'b1, 5'd31);
                3:       program_tracker(1'b0, 5'd16);
                4:       program_tracker(1'b1, 5'd0);
                default: program_tracker($urandom_range(0, 3) != 0, 5'($urandom_range(2, 15)));
            endcase
            // receiver holds off while the sender keeps offering
            if (phase == 2)
                hold_req = 1'b1;
            repeat (RANDOM_ITEMS / PHASES)
                send_cmd(make_cmd(), 1'b0, '0);
        end

        finish_outstanding();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
